>>> hw/rtl/kline_response_frame_checker_unit_macros.svh
// assertion helpers for the k-line response frame checker
// clk and rst_n are taken from the module that uses them
`ifndef KLINE_RESPONSE_FRAME_CHECKER_UNIT_MACROS_SVH
`define KLINE_RESPONSE_FRAME_CHECKER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// consequent holds in the same cycle as the antecedent
`define KRFC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("krfc assertion failed");
// consequent holds in the cycle after the antecedent
`define KRFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("krfc assertion failed");
`else
`define KRFC_ASSERT_SAME(lbl, ante, cons)
`define KRFC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/krfc_pkg.sv
`timescale 1ns / 1ps

package krfc_pkg;

    localparam int COUNT_BITS = 8;
    localparam int CFG_INDEX_BITS = 2;

    typedef logic [COUNT_BITS-1:0] count_t;

    localparam count_t COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam count_t MIN_FRAME_LEN = count_t'(4);

    localparam logic [CFG_INDEX_BITS-1:0] REG_TESTER_ADDR = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODULE_ADDR = 2'd1;

    localparam logic [7:0] TESTER_ADDR_RST = 8'hF0;
    localparam logic [7:0] MODULE_ADDR_RST = 8'h40;

    localparam int FMT_ADDR_BIT = 7;
    localparam logic [7:0] FMT_LEN_MASK = 8'h7F;

    localparam logic [7:0] RSP_CONNECT = 8'hC1;
    localparam logic [7:0] RSP_DISCONNECT = 8'hC2;
    localparam logic [7:0] RSP_DTC_READ = 8'h58;
    localparam logic [7:0] RSP_DTC_CLEAR = 8'h54;
    localparam logic [7:0] RSP_DATA = 8'h61;
    localparam logic [7:0] RSP_NEGATIVE = 8'h7F;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_HEADER   = 2'd1,
        ST_LENGTH   = 2'd2,
        ST_CHECKSUM = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        KIND_CONNECT    = 3'd0,
        KIND_DISCONNECT = 3'd1,
        KIND_DTC_READ   = 3'd2,
        KIND_DTC_CLEAR  = 3'd3,
        KIND_DATA       = 3'd4,
        KIND_NEGATIVE   = 3'd5,
        KIND_OTHER      = 3'd6
    } kind_t;

    // frame summary as seen with the current byte folded in, except the sum, which covers only earlier bytes
    typedef struct packed {
        count_t     len;
        logic [7:0] sum;
        logic [7:0] fmt;
        logic       fault;
        logic [7:0] svc;
        logic [7:0] ident;
    } frame_info_t;

    typedef struct packed {
        status_t    status;
        kind_t      kind;
        logic [7:0] lid;
        logic [6:0] payload;
        logic       link_set;
        logic       link_clr;
    } check_res_t;

endpackage

>>> hw/rtl/krfc_accum.sv
`timescale 1ns / 1ps

module krfc_accum
    import krfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  tester_addr,
    input  logic [7:0]  module_addr,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    input  logic        take,
    output frame_info_t info
);

    count_t     count_reg;
    logic [7:0] sum_reg;
    logic [7:0] fmt_reg;
    logic       fault_reg;
    logic [7:0] svc_reg;
    logic [7:0] ident_reg;

    frame_info_t info_next;

    always_comb
    begin
        info_next.len   = (count_reg == COUNT_MAX) ? count_reg : count_reg + count_t'(1);
        info_next.sum   = sum_reg;
        info_next.fmt   = (count_reg == count_t'(0)) ? rx_byte : fmt_reg;
        info_next.fault = fault_reg
                        | ((count_reg == count_t'(0)) & ~rx_byte[FMT_ADDR_BIT])
                        | ((count_reg == count_t'(1)) & (rx_byte != tester_addr))
                        | ((count_reg == count_t'(2)) & (rx_byte != module_addr));
        info_next.svc   = (count_reg == count_t'(3)) ? rx_byte : svc_reg;
        info_next.ident = (count_reg == count_t'(4)) ? rx_byte : ident_reg;
    end

    assign info = info_next;

    // state returns to zero after the last byte of each frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
            fmt_reg   <= '0;
            fault_reg <= 1'b0;
            svc_reg   <= '0;
            ident_reg <= '0;
        end
        else if (take)
        begin
            if (frame_end)
            begin
                count_reg <= '0;
                sum_reg   <= '0;
                fmt_reg   <= '0;
                fault_reg <= 1'b0;
                svc_reg   <= '0;
                ident_reg <= '0;
            end
            else
            begin
                count_reg <= info_next.len;
                sum_reg   <= sum_reg + rx_byte;
                fmt_reg   <= info_next.fmt;
                fault_reg <= info_next.fault;
                svc_reg   <= info_next.svc;
                ident_reg <= info_next.ident;
            end
        end
    end

endmodule

>>> hw/rtl/krfc_check.sv
`timescale 1ns / 1ps

module krfc_check
    import krfc_pkg::*;
(
    input  frame_info_t info,
    input  logic [7:0]  rx_byte,
    output check_res_t  res
);

    count_t     body_len;
    logic [7:0] fmt_len;

    assign fmt_len  = info.fmt & FMT_LEN_MASK;
    assign body_len = info.len - MIN_FRAME_LEN;

    always_comb
    begin
        res.payload  = fmt_len[6:0];
        res.kind     = KIND_OTHER;
        res.lid      = '0;
        res.link_set = 1'b0;
        res.link_clr = 1'b0;

        // header, then length, then sum; short frames are a length error
        priority if (info.len < MIN_FRAME_LEN)
            res.status = ST_LENGTH;
        else if (info.fault)
            res.status = ST_HEADER;
        else if (count_t'(fmt_len) != body_len)
            res.status = ST_LENGTH;
        else if (info.sum != rx_byte)
            res.status = ST_CHECKSUM;
        else
            res.status = ST_OK;

        if (res.status == ST_OK)
        begin
            unique case (info.svc)
                RSP_CONNECT:
                begin
                    res.kind     = KIND_CONNECT;
                    res.link_set = 1'b1;
                end
                RSP_DISCONNECT:
                begin
                    res.kind     = KIND_DISCONNECT;
                    res.link_clr = 1'b1;
                end
                RSP_DTC_READ:  res.kind = KIND_DTC_READ;
                RSP_DTC_CLEAR: res.kind = KIND_DTC_CLEAR;
                RSP_DATA:
                begin
                    res.kind = KIND_DATA;
                    res.lid  = info.ident;
                end
                RSP_NEGATIVE:  res.kind = KIND_NEGATIVE;
                default:       res.kind = KIND_OTHER;
            endcase
        end
    end

endmodule

>>> hw/rtl/kline_response_frame_checker_unit.sv
// k-line response frame checker, one received byte per transaction
// result: the result of a frame is valid the cycle after its last byte is taken
// throughput: one byte per cycle while no result waits, set by the single registered pass through the checks
// a waiting result holds off every input byte until out_ready takes it
// reset: frame state and link flag cleared, addresses back to 0xF0 and 0x40
`timescale 1ns / 1ps
`include "kline_response_frame_checker_unit_macros.svh"

module kline_response_frame_checker_unit
    import krfc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [7:0]                cfg_data,

    // byte input channel
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                rx_byte,
    input  logic                      frame_end,

    // frame result channel
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [1:0]                frame_status,
    output logic [2:0]                reply_kind,
    output logic [7:0]                local_id,
    output logic [6:0]                payload_count,
    output logic                      link_up
);

    logic [7:0]  tester_addr_reg;
    logic [7:0]  module_addr_reg;
    logic        connected_reg;
    logic        connected_next;

    logic        out_valid_reg;
    status_t     status_reg;
    kind_t       kind_reg;
    logic [7:0]  lid_reg;
    logic [6:0]  payload_reg;
    logic        link_reg;

    logic        in_fire;
    logic        res_load;
    frame_info_t info;
    check_res_t  res;

    // configuration is always taken; indexes past the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tester_addr_reg <= TESTER_ADDR_RST;
            module_addr_reg <= MODULE_ADDR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_TESTER_ADDR)
                tester_addr_reg <= cfg_data;
            else if (cfg_index == REG_MODULE_ADDR)
                module_addr_reg <= cfg_data;
        end
    end

    // take a byte whenever the result register is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;
    assign res_load = in_fire && frame_end;

    // running frame state: count, sum and captured header bytes
    krfc_accum u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .tester_addr (tester_addr_reg),
        .module_addr (module_addr_reg),
        .rx_byte     (rx_byte),
        .frame_end   (frame_end),
        .take        (in_fire),
        .info        (info)
    );

    // end of frame checks and reply classification
    krfc_check u_check (
        .info    (info),
        .rx_byte (rx_byte),
        .res     (res)
    );

    // link flag follows connect and disconnect acknowledges only
    always_comb
    begin
        connected_next = connected_reg;
        if (res.link_set)
            connected_next = 1'b1;
        else if (res.link_clr)
            connected_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                connected_reg <= connected_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, held while the transaction stalls
    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            status_reg  <= res.status;
            kind_reg    <= res.kind;
            lid_reg     <= res.lid;
            payload_reg <= res.payload;
            link_reg    <= connected_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_status  = status_reg;
    assign reply_kind    = kind_reg;
    assign local_id      = lid_reg;
    assign payload_count = payload_reg;
    assign link_up       = link_reg;

    // a rejected frame never carries a reply kind
    `KRFC_ASSERT_SAME(a_reject_is_other, out_valid_reg && (status_reg != ST_OK), (kind_reg == KIND_OTHER) && (lid_reg == 8'd0))
    // only a data reply shows a local id
    `KRFC_ASSERT_SAME(a_lid_data_only, out_valid_reg && (kind_reg != KIND_DATA), lid_reg == 8'd0)
    // the link flag moves only on a frame end
    `KRFC_ASSERT_NEXT(a_link_stable, !res_load, $stable(connected_reg))
    // a good connect acknowledge brings the link up
    `KRFC_ASSERT_NEXT(a_connect_up, res_load && (res.status == ST_OK) && (res.kind == KIND_CONNECT), connected_reg && link_reg)
    // an empty result register never holds back input
    `KRFC_ASSERT_SAME(a_ready_when_empty, !out_valid_reg, in_ready)

endmodule
